@@ rtl/htb_pkg.sv @@
package htb_pkg;

   localparam int SYMBOLS     = 256;
   localparam int FREQ_BITS   = 32;
   localparam int WEIGHT_BITS = 40;
   localparam int NODE_BITS   = 9;
   localparam int MERGE_BITS  = 8;
   localparam int COUNT_BITS  = $clog2(SYMBOLS + 1);

   localparam logic [1:0] FUNC_CLEAR = 2'd0;
   localparam logic [1:0] FUNC_LOAD  = 2'd1;
   localparam logic [1:0] FUNC_MERGE = 2'd2;

   localparam logic [1:0] OP_HOLD   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_SHIFT2 = 2'd2;

   localparam logic [NODE_BITS-1:0] INTERNAL_BASE = 9'd256;

   typedef struct packed {
      logic [1:0]             op;
      logic                   le_mode;
      logic [WEIGHT_BITS-1:0] key_weight;
      logic [NODE_BITS-1:0]   key_node;
   } ctl_type;

endpackage

@@ rtl/htb_cell.sv @@
module htb_cell
   import htb_pkg::*;
(
   input  logic                   clock,
   input  ctl_type                ctl,
   input  logic                   live,
   input  logic                   prev_less,
   input  logic [WEIGHT_BITS-1:0] prev_weight,
   input  logic [NODE_BITS-1:0]   prev_node,
   input  logic [WEIGHT_BITS-1:0] next2_weight,
   input  logic [NODE_BITS-1:0]   next2_node,
   output logic [WEIGHT_BITS-1:0] entry_weight,
   output logic [NODE_BITS-1:0]   entry_node,
   output logic                   less
);

   logic [WEIGHT_BITS-1:0] weight_ff, weight_in;
   logic [NODE_BITS-1:0]   node_ff, node_in;

   always_comb begin
      if (ctl.le_mode) begin
         less = live && (weight_ff <= ctl.key_weight);
      end else begin
         less = live && ((weight_ff < ctl.key_weight) ||
                         ((weight_ff == ctl.key_weight) && (node_ff < ctl.key_node)));
      end
   end

   always_comb begin
      weight_in = weight_ff;
      node_in   = node_ff;
      case (ctl.op)
         OP_INSERT: begin
            if (!less) begin
               if (prev_less) begin
                  weight_in = ctl.key_weight;
                  node_in   = ctl.key_node;
               end else begin
                  weight_in = prev_weight;
                  node_in   = prev_node;
               end
            end
         end
         OP_SHIFT2: begin
            weight_in = next2_weight;
            node_in   = next2_node;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      weight_ff <= weight_in;
      node_ff   <= node_in;
   end

   assign entry_weight = weight_ff;
   assign entry_node   = node_ff;

endmodule

@@ rtl/huffman_tree_builder.sv @@
// Huffman tree builder over a sorted row of cells, one entry per cell.
// Input channel req_*: func selects clear, load (symbol, freq) or merge.
// Result channel rsp_*: one merge record per merge item; clear and load
// items and the unused func code give no result.
// csr_wr_en / csr_wr_data write expected_symbols.
// A load item that passes its checks makes every cell compare its entry
// with the new key and keep, take the key or take its lower neighbour; a
// clear item only resets the count, merge counter and count check. A merge
// item that joins two entries first adds the two lightest entries, moves
// the row down by two and registers the record, then inserts the new node.
// The record appears in the cycle after the merge is accepted. New items
// wait while the insert pass of a joining merge runs through the cell row.
// Reset empties the list, zeroes the merge counter, the count check and
// expected_symbols; the cell contents are not cleared.
// While a record waits on rsp_ready low it holds; load and clear items are
// still taken, a merge item waits until the record is taken.
module huffman_tree_builder
   import htb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_func,
   input  logic [7:0]             req_symbol,
   input  logic [31:0]            req_freq,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [NODE_BITS-1:0]   rsp_left_node,
   output logic [NODE_BITS-1:0]   rsp_right_node,
   output logic [NODE_BITS-1:0]   rsp_new_node,
   output logic [WEIGHT_BITS-1:0] rsp_weight,
   output logic                   rsp_done_res,
   output logic                   rsp_error,
   input  logic                   csr_wr_en,
   input  logic [8:0]             csr_wr_data
);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_INSERT = 1'b1;
   localparam logic [63:0] FREQ_MASK = (64'd1 << FREQ_BITS) - 64'd1;

   logic                   state_ff, state_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [MERGE_BITS-1:0]  merges_ff, merges_in;
   logic                   checked_ff, checked_in;
   logic [8:0]             expected_ff;
   logic [WEIGHT_BITS-1:0] key_weight_ff, key_weight_in;
   logic [NODE_BITS-1:0]   key_node_ff, key_node_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [NODE_BITS-1:0]   left_ff, left_in, right_ff, right_in, new_ff, new_in;
   logic [WEIGHT_BITS-1:0] weight_ff, weight_in;
   logic                   done_ff, done_in, error_ff, error_in;

   ctl_type                ctl;
   logic [WEIGHT_BITS-1:0] cw [SYMBOLS];
   logic [NODE_BITS-1:0]   cn [SYMBOLS];
   logic [SYMBOLS-1:0]     cless;
   logic [SYMBOLS-1:0]     live;

   logic                   accept;
   logic [31:0]            freq_m;
   logic                   load_ok;
   logic                   merge_err;
   logic [WEIGHT_BITS:0]   sum_raw;
   logic [WEIGHT_BITS-1:0] sum_sat;

   assign req_ready = (state_ff == ST_IDLE) &&
                      (!rsp_valid_ff || rsp_ready || (req_func != FUNC_MERGE));
   assign accept    = req_valid && req_ready;
   assign freq_m    = req_freq & FREQ_MASK[31:0];
   assign load_ok   = (freq_m != 32'd0) && ({1'b0, req_symbol} < 9'(SYMBOLS)) &&
                      (count_ff != COUNT_BITS'(SYMBOLS));
   assign merge_err = (count_ff == '0) ||
                      (!checked_ff && (9'(count_ff) != expected_ff));
   assign sum_raw   = {1'b0, cw[0]} + {1'b0, cw[1]};
   assign sum_sat   = sum_raw[WEIGHT_BITS] ? '1 : sum_raw[WEIGHT_BITS-1:0];

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      merges_in      = merges_ff;
      checked_in     = checked_ff;
      key_weight_in  = key_weight_ff;
      key_node_in    = key_node_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      left_in        = left_ff;
      right_in       = right_ff;
      new_in         = new_ff;
      weight_in      = weight_ff;
      done_in        = done_ff;
      error_in       = error_ff;
      ctl.op         = OP_HOLD;
      ctl.le_mode    = 1'b0;
      ctl.key_weight = {{(WEIGHT_BITS-32){1'b0}}, freq_m};
      ctl.key_node   = {1'b0, req_symbol};
      if (state_ff == ST_INSERT) begin
         ctl.op         = OP_INSERT;
         ctl.le_mode    = 1'b1;
         ctl.key_weight = key_weight_ff;
         ctl.key_node   = key_node_ff;
         count_in       = count_ff + 1'b1;
         state_in       = ST_IDLE;
      end else if (accept) begin
         case (req_func)
            FUNC_CLEAR: begin
               count_in   = '0;
               merges_in  = '0;
               checked_in = 1'b0;
            end
            FUNC_LOAD: begin
               if (load_ok) begin
                  ctl.op   = OP_INSERT;
                  count_in = count_ff + 1'b1;
               end
            end
            FUNC_MERGE: begin
               rsp_valid_in = 1'b1;
               left_in      = '0;
               right_in     = '0;
               new_in       = '0;
               weight_in    = '0;
               done_in      = 1'b0;
               error_in     = 1'b0;
               if (merge_err) begin
                  error_in = 1'b1;
               end else begin
                  checked_in = 1'b1;
                  if (count_ff == COUNT_BITS'(1)) begin
                     done_in   = 1'b1;
                     new_in    = cn[0];
                     weight_in = cw[0];
                  end else begin
                     left_in       = cn[0];
                     right_in      = cn[1];
                     new_in        = INTERNAL_BASE | NODE_BITS'(merges_ff);
                     weight_in     = sum_sat;
                     key_weight_in = sum_sat;
                     key_node_in   = INTERNAL_BASE | NODE_BITS'(merges_ff);
                     merges_in     = merges_ff + 1'b1;
                     count_in      = count_ff - COUNT_BITS'(2);
                     ctl.op        = OP_SHIFT2;
                     state_in      = ST_INSERT;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   genvar i;
   generate
      for (i = 0; i < SYMBOLS; i++) begin : g_cell
         logic                   p_less;
         logic [WEIGHT_BITS-1:0] p_w, n2_w;
         logic [NODE_BITS-1:0]   p_n, n2_n;

         assign live[i] = (COUNT_BITS'(i) < count_ff);

         if (i == 0) begin : g_first
            assign p_less = 1'b1;
            assign p_w    = '0;
            assign p_n    = '0;
         end else begin : g_rest
            assign p_less = cless[i-1];
            assign p_w    = cw[i-1];
            assign p_n    = cn[i-1];
         end

         if (i + 2 < SYMBOLS) begin : g_n2
            assign n2_w = cw[i+2];
            assign n2_n = cn[i+2];
         end else begin : g_n2_end
            assign n2_w = '0;
            assign n2_n = '0;
         end

         htb_cell u_cell (
            .clock        (clock),
            .ctl          (ctl),
            .live         (live[i]),
            .prev_less    (p_less),
            .prev_weight  (p_w),
            .prev_node    (p_n),
            .next2_weight (n2_w),
            .next2_node   (n2_n),
            .entry_weight (cw[i]),
            .entry_node   (cn[i]),
            .less         (cless[i])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         merges_ff    <= '0;
         checked_ff   <= 1'b0;
         expected_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         merges_ff    <= merges_in;
         checked_ff   <= checked_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            expected_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_weight_ff <= key_weight_in;
      key_node_ff   <= key_node_in;
      left_ff       <= left_in;
      right_ff      <= right_in;
      new_ff        <= new_in;
      weight_ff     <= weight_in;
      done_ff       <= done_in;
      error_ff      <= error_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_left_node  = left_ff;
   assign rsp_right_node = right_ff;
   assign rsp_new_node   = new_ff;
   assign rsp_weight     = weight_ff;
   assign rsp_done_res   = done_ff;
   assign rsp_error      = error_ff;

   a_insert_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INSERT) |-> !req_ready)
      else $error("item accepted during insert pass");

   a_insert_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INSERT) |=> (state_ff == ST_IDLE))
      else $error("insert pass longer than one cycle");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(SYMBOLS))
      else $error("entry count beyond row length");

   a_done_no_err: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_res) |-> !rsp_error)
      else $error("done and error together");

   a_merge_record: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INSERT) |-> (rsp_valid_ff && !rsp_error && !rsp_done_res &&
                                   (rsp_new_node == key_node_ff)))
      else $error("merge record does not match inserted node");

endmodule
